/* src/sesb_pkg.sv */
// Types and codes shared by the sorted edge schedule builder.
// No dependencies; compile first.
package sesb_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MERGED = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADCH  = 2'd3
  } status_t;

  localparam int HALF_SHIFT = 16;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  channel;
    logic        edge_is_odd;
    logic [31:0] edge_time;
    logic [5:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic [31:0] entry_time;
    logic [31:0] entry_pins;
    logic        times_rotated;
  } out_item_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_PREP, CMD_SCAN_RD, CMD_NEXT, CMD_MERGE,
    CMD_SH_INIT, CMD_APPEND_INIT, CMD_SH_RD, CMD_SH_WR, CMD_INSERT,
    CMD_START, CMD_STOP, CMD_ROT_RD0, CMD_ROT_SAVE, CMD_ROT_RD,
    CMD_ROT_WR, CMD_ROT_LAST, CMD_RD_ENTRY, CMD_RD_CAP, CMD_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    op_t  opcode;
    logic bad_ch;
    logic empty;
    logic full;
    logic eq;
    logic gt;
    logic last;
    logic at_pos;
    logic rot_go;
    logic out_free;
  } dp_stat_t;

endpackage

/* src/sesb_chan_if.sv */
// Valid/ready channel carrying one payload beat of type T.
// Depends on nothing; payload types come from sesb_pkg at instantiation.
interface sesb_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/sorted_edge_schedule_builder_core.sv */
// Sorted edge schedule builder: keeps up to TABLE_DEPTH (time, pin word)
// entries in time order and returns one result beat per command beat. An add
// searches from entry 0, one entry at a time, then, for a new time, shifts
// later entries up one at a time; the first start after a fill rotates the
// time column. No clearing pass is needed after reset: entries at or above
// the count read as zero. A new command beat is taken once the previous one is
// finished, while its result may still wait in the output register.
module sorted_edge_schedule_builder_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int CHANNELS    = 16
) (
  input logic        clk,
  input logic        rst_n,
  sesb_chan_if.sink   in_ch,
  sesb_chan_if.source out_ch,
  sesb_chan_if.sink   cfg_ch
);
  import sesb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  sesb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sesb_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CHANNELS    (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch.data),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.data)
  );

endmodule

/* src/sesb_ctrl.sv */
// Sequencer for the schedule builder: steps the datapath through search,
// shift, rotate and read. Uses sesb_pkg command and status types.
module sesb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sesb_pkg::dp_stat_t stat,
  output sesb_pkg::dp_cmd_t  cmd
);
  import sesb_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE     = 13'h0001,
    S_DISP     = 13'h0002,
    S_CHECK    = 13'h0004,
    S_SCAN_RD  = 13'h0008,
    S_SCAN_CHK = 13'h0010,
    S_SH_CHK   = 13'h0020,
    S_SH_WR    = 13'h0040,
    S_ROT_CHK  = 13'h0080,
    S_ROT_SAVE = 13'h0100,
    S_ROT_LOOP = 13'h0200,
    S_ROT_WR   = 13'h0400,
    S_RD_CAP   = 13'h0800,
    S_FIN      = 13'h1000
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  dp_op_t  op;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    op        = CMD_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        st_nxt = ST_OK;
        case (stat.opcode)
          OP_ADD: begin
            op = CMD_PREP; state_nxt = S_CHECK;
          end
          OP_START: begin
            op = CMD_START; state_nxt = S_ROT_CHK;
          end
          OP_STOP: begin
            op = CMD_STOP; state_nxt = S_FIN;
          end
          default: begin
            op = CMD_RD_ENTRY; state_nxt = S_RD_CAP;
          end
        endcase
      end
      S_CHECK: begin
        if (stat.bad_ch) begin
          st_nxt = ST_BADCH; state_nxt = S_FIN;
        end else if (stat.empty) begin
          op = CMD_APPEND_INIT; state_nxt = S_SH_CHK;
        end else begin
          op = CMD_SCAN_RD; state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_RD: begin
        op = CMD_SCAN_RD; state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.eq) begin
          op = CMD_MERGE; st_nxt = ST_MERGED; state_nxt = S_FIN;
        end else if (stat.gt || stat.last) begin
          if (stat.full) begin
            st_nxt = ST_FULL; state_nxt = S_FIN;
          end else begin
            // insert before the larger entry, or after the last one
            op = stat.gt ? CMD_SH_INIT : CMD_APPEND_INIT;
            state_nxt = S_SH_CHK;
          end
        end else begin
          op = CMD_NEXT; state_nxt = S_SCAN_RD;
        end
      end
      S_SH_CHK: begin
        if (stat.at_pos) begin
          op = CMD_INSERT; state_nxt = S_FIN;
        end else begin
          op = CMD_SH_RD; state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        op = CMD_SH_WR; state_nxt = S_SH_CHK;
      end
      S_ROT_CHK: begin
        if (stat.rot_go) begin
          op = CMD_ROT_RD0; state_nxt = S_ROT_SAVE;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_ROT_SAVE: begin
        op = CMD_ROT_SAVE; state_nxt = S_ROT_LOOP;
      end
      S_ROT_LOOP: begin
        if (stat.last) begin
          op = CMD_ROT_LAST; state_nxt = S_FIN;
        end else begin
          op = CMD_ROT_RD; state_nxt = S_ROT_WR;
        end
      end
      S_ROT_WR: begin
        op = CMD_ROT_WR; state_nxt = S_ROT_LOOP;
      end
      S_RD_CAP: begin
        op = CMD_RD_CAP; state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          op = CMD_FIN; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cmd.op     = op;
  assign cmd.status = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

/* src/sesb_dp.sv */
// Datapath of the schedule builder: time and pin memories, count, index
// and result registers. Uses sesb_pkg; driven by sesb_ctrl commands.
module sesb_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int CHANNELS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sesb_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  sesb_pkg::dp_cmd_t   cmd,
  output sesb_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output sesb_pkg::out_item_t out_item
);
  import sesb_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [31:0] time_mem [TABLE_DEPTH];
  logic [31:0] pin_mem  [TABLE_DEPTH];

  in_item_t    item_r;
  logic [15:0] rev_r;
  logic [CW-1:0] count_r, idx_r, pos_r;
  logic [31:0] first_r, rd_time_r, rd_pin_r, res_time_r, res_pins_r;
  logic        clear_r, rotp_r, rot_r, out_valid_r;
  out_item_t   out_r;

  logic [CW-1:0] idx_m1, idx_p1;
  logic [31:0]   bits, mask;
  logic          hit;
  logic          rd_en, we_t, we_p;
  logic [AW-1:0] ra, wa;
  logic [31:0]   wd_t, wd_p;

  assign idx_m1 = idx_r - CW'(1);
  assign idx_p1 = idx_r + CW'(1);
  assign mask   = 32'(1) << item_r.channel;
  assign bits   = (item_r.edge_is_odd ^ rev_r[item_r.channel]) ? (mask << HALF_SHIFT) : mask;
  assign hit    = 32'(item_r.read_index) < 32'(count_r);

  always_comb begin
    rd_en = 1'b0;
    ra    = idx_r[AW-1:0];
    we_t  = 1'b0;
    we_p  = 1'b0;
    wa    = idx_r[AW-1:0];
    wd_t  = rd_time_r;
    wd_p  = rd_pin_r;
    case (cmd.op)
      CMD_SCAN_RD:  rd_en = 1'b1;
      CMD_SH_RD: begin
        rd_en = 1'b1; ra = idx_m1[AW-1:0];
      end
      CMD_ROT_RD0: begin
        rd_en = 1'b1; ra = '0;
      end
      CMD_ROT_RD: begin
        rd_en = 1'b1; ra = idx_p1[AW-1:0];
      end
      CMD_RD_ENTRY: begin
        rd_en = 1'b1; ra = AW'(item_r.read_index);
      end
      CMD_MERGE: begin
        we_p = 1'b1; wd_p = rd_pin_r | bits;
      end
      CMD_SH_WR: begin
        we_t = 1'b1; we_p = 1'b1;
      end
      CMD_INSERT: begin
        we_t = 1'b1; we_p = 1'b1; wd_t = item_r.edge_time; wd_p = bits;
      end
      CMD_ROT_WR:   we_t = 1'b1;
      CMD_ROT_LAST: begin
        we_t = 1'b1; wd_t = first_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_t) time_mem[wa] <= wd_t;
    if (we_p) pin_mem[wa]  <= wd_p;
    if (rd_en) begin
      rd_time_r <= time_mem[ra];
      rd_pin_r  <= pin_mem[ra];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clear_r     <= 1'b1;
      rotp_r      <= 1'b1;
      rev_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) rev_r <= cfg_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        CMD_PREP: begin
          // a fresh table just drops its count; entries above it read as zero
          if (clear_r) begin
            count_r <= '0;
            rotp_r  <= 1'b1;
            clear_r <= 1'b0;
          end
        end
        CMD_INSERT: count_r <= count_r + CW'(1);
        CMD_START: begin
          if (rotp_r) rotp_r <= 1'b0;
          clear_r <= 1'b1;
        end
        CMD_STOP: clear_r <= 1'b1;
        CMD_FIN:  out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        item_r     <= in_item;
        rot_r      <= 1'b0;
        res_time_r <= '0;
        res_pins_r <= '0;
      end
      CMD_PREP:        idx_r <= '0;
      CMD_NEXT:        idx_r <= idx_p1;
      CMD_SH_INIT: begin
        pos_r <= idx_r; idx_r <= count_r;
      end
      CMD_APPEND_INIT: begin
        pos_r <= count_r; idx_r <= count_r;
      end
      CMD_SH_WR:       idx_r <= idx_m1;
      CMD_START:       if (rotp_r) rot_r <= 1'b1;
      CMD_ROT_RD0:     idx_r <= '0;
      CMD_ROT_SAVE:    first_r <= rd_time_r;
      CMD_ROT_WR:      idx_r <= idx_p1;
      CMD_RD_CAP: begin
        if (hit) begin
          res_time_r <= rd_time_r;
          res_pins_r <= rd_pin_r;
        end
      end
      CMD_FIN: begin
        out_r.status        <= cmd.status;
        out_r.entry_count   <= 7'(count_r);
        out_r.entry_time    <= res_time_r;
        out_r.entry_pins    <= res_pins_r;
        out_r.times_rotated <= rot_r;
      end
      default: ;
    endcase
  end

  assign stat.opcode   = op_t'(item_r.opcode);
  assign stat.bad_ch   = 32'(item_r.channel) >= 32'(CHANNELS);
  assign stat.empty    = count_r == '0;
  assign stat.full     = count_r == CW'(TABLE_DEPTH);
  assign stat.eq       = rd_time_r == item_r.edge_time;
  assign stat.gt       = rd_time_r > item_r.edge_time;
  assign stat.last     = idx_p1 == count_r;
  assign stat.at_pos   = idx_r == pos_r;
  assign stat.rot_go   = rot_r && (count_r > CW'(1));
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CMD_INSERT |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the table");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CMD_SH_RD |-> idx_r > pos_r)
    else $error("shift ran past insert position");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CMD_FIN |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken beat");

endmodule

/* tb/sv/sesb_sched_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the sorted edge schedule builder: watches the command, result
// and register channels, keeps its own copy of the schedule table and checks results.
// Depends on sesb_pkg.
module sesb_sched_checker
  import sesb_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int NCH   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  logic      cmd_ready,
  input  in_item_t  cmd_data,
  input  logic      res_valid,
  input  logic      res_ready,
  input  out_item_t res_data,
  input  logic      reg_valid,
  input  logic      reg_ready,
  input  logic [15:0] reg_data,
  output int        pending,
  output int        errors
);

  logic [31:0] sched_time [DEPTH];
  logic [31:0] sched_pins [DEPTH];
  int unsigned n_entries;
  logic        clear_armed;
  logic        rot_armed;
  logic [15:0] rev_mask;
  out_item_t   want_q[$];

  function automatic void wipe_schedule();
    for (int i = 0; i < DEPTH; i++) begin
      sched_time[i] = '0;
      sched_pins[i] = '0;
    end
    n_entries = 0;
  endfunction

  function automatic status_t place_entry(int unsigned pos, logic [31:0] t, logic [31:0] bits);
    if (n_entries >= DEPTH || pos > n_entries) return ST_FULL;
    for (int unsigned i = n_entries; i > pos; i--) begin
      sched_time[i] = sched_time[i-1];
      sched_pins[i] = sched_pins[i-1];
    end
    sched_time[pos] = t;
    sched_pins[pos] = bits;
    n_entries++;
    return ST_OK;
  endfunction

  function automatic status_t add_edge(logic [3:0] ch, logic odd, logic [31:0] t);
    logic [31:0] bits;
    if (clear_armed) begin
      rot_armed = 1'b1;
      wipe_schedule();
      clear_armed = 1'b0;
    end
    if (ch >= NCH) return ST_BADCH;
    bits = 32'd1 << ch;
    if ((odd ^ rev_mask[ch]) != 1'b0) bits = bits << HALF_SHIFT;
    if (n_entries == 0 || t < sched_time[0]) return place_entry(0, t, bits);
    if (t > sched_time[n_entries-1]) return place_entry(n_entries, t, bits);
    for (int unsigned i = 0; i < n_entries; i++) begin
      if (sched_time[i] == t) begin
        sched_pins[i] |= bits;
        return ST_MERGED;
      end
    end
    for (int unsigned i = 0; i < n_entries; i++)
      if (sched_time[i] > t) return place_entry(i, t, bits);
    return ST_OK;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    logic [31:0] first;
    r = '0;
    case (op_t'(it.opcode))
      OP_ADD: r.status = add_edge(it.channel, it.edge_is_odd, it.edge_time);
      OP_START: begin
        if (rot_armed) begin
          if (n_entries > 0) begin
            first = sched_time[0];
            for (int unsigned i = 0; i + 1 < n_entries; i++) sched_time[i] = sched_time[i+1];
            sched_time[n_entries-1] = first;
          end
          rot_armed = 1'b0;
          r.times_rotated = 1'b1;
        end
        clear_armed = 1'b1;
      end
      OP_STOP: clear_armed = 1'b1;
      default: begin
        if (it.read_index < DEPTH) begin
          r.entry_time = sched_time[it.read_index];
          r.entry_pins = sched_pins[it.read_index];
        end
      end
    endcase
    r.entry_count = n_entries[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      wipe_schedule();
      clear_armed = 1'b1;
      rot_armed   = 1'b1;
      rev_mask    = '0;
      want_q.delete();
      errors      <= 0;
    end else begin
      if (reg_valid && reg_ready) rev_mask = reg_data;
      if (cmd_valid && cmd_ready) want_q.push_back(predict_result(cmd_data));
      if (res_valid && res_ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h", $time, res_data);
          errors <= errors + 1;
        end else begin
          want = want_q.pop_front();
          if (want !== res_data) begin
            $display("%0t: mismatch exp st=%0d cnt=%0d t=%h pins=%h rot=%0d", $time,
                     want.status, want.entry_count, want.entry_time, want.entry_pins,
                     want.times_rotated);
            $display("%0t:          act st=%0d cnt=%0d t=%h pins=%h rot=%0d", $time,
                     res_data.status, res_data.entry_count, res_data.entry_time,
                     res_data.entry_pins, res_data.times_rotated);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  assign pending = want_q.size();

endmodule

/* tb/sv/sorted_edge_schedule_builder_core_tb.sv */
`timescale 1ns / 1ps
// Top of the schedule builder testbench: clock, reset, command and register
// stimulus, result back-pressure and verdict. Depends on sesb_pkg, sesb_chan_if,
// the core and sesb_sched_checker.
module sorted_edge_schedule_builder_core_tb;
  import sesb_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   pending;
  int   errors;
  int   burst_left = 0;
  int   idle_cycles = 0;
  int   stall_mode = 0;
  int   n_sent = 0;
  logic [31:0] time_pool [16];

  sesb_chan_if #(.T(in_item_t))    in_ch ();
  sesb_chan_if #(.T(out_item_t))   out_ch ();
  sesb_chan_if #(.T(logic [15:0])) cfg_ch ();

  sorted_edge_schedule_builder_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  sesb_sched_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(in_ch.valid), .cmd_ready(in_ch.ready), .cmd_data(in_ch.data),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_data(out_ch.data),
    .reg_valid(cfg_ch.valid), .reg_ready(cfg_ch.ready), .reg_data(cfg_ch.data),
    .pending(pending), .errors(errors)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: change stall pattern now and then, including long runs of no stall
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 1) != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** sorted_edge_schedule_builder_core: FAILED **");
      $finish;
    end
  end

  task automatic send_beat(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    n_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reversed(logic [15:0] v);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic in_item_t make_cmd(op_t op, logic [3:0] ch, logic odd,
                                        logic [31:0] t, logic [5:0] idx);
    in_item_t it;
    it.opcode = op;
    it.channel = ch;
    it.edge_is_odd = odd;
    it.edge_time = t;
    it.read_index = idx;
    return it;
  endfunction

  function automatic in_item_t rand_add(bit wide);
    logic [31:0] t;
    case ($urandom_range(0, 9))
      0: t = 32'hFFFF_FFFF;
      1: t = 32'h0;
      2, 3, 4: t = time_pool[$urandom_range(0, 15)];
      default: t = wide ? $urandom() : $urandom_range(0, 400);
    endcase
    return make_cmd(OP_ADD, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), t,
                    6'($urandom_range(0, 63)));
  endfunction

  function automatic in_item_t rand_read();
    return make_cmd(OP_READ, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    $urandom(), 6'($urandom_range(0, 63)));
  endfunction

  initial begin
    int n_adds;
    in_item_t it;
    logic [15:0] cfg_vals [5];
    cfg_vals = '{16'h0000, 16'hFFFF, 16'hA5C3, 16'h8001, 16'h0000};
    for (int i = 0; i < 16; i++) time_pool[i] = $urandom_range(0, 400);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: start on empty table, merges, extremes, middle insert, rotate
    send_beat(make_cmd(OP_START, 4'd0, 1'b0, 32'd0, 6'd0));
    send_beat(make_cmd(OP_ADD, 4'd0, 1'b0, 32'd100, 6'd0));
    send_beat(make_cmd(OP_ADD, 4'd15, 1'b1, 32'd100, 6'd0));
    send_beat(make_cmd(OP_ADD, 4'd7, 1'b1, 32'h0, 6'd0));
    send_beat(make_cmd(OP_ADD, 4'd8, 1'b0, 32'hFFFF_FFFF, 6'd0));
    send_beat(make_cmd(OP_ADD, 4'd3, 1'b0, 32'd50, 6'd0));
    send_beat(make_cmd(OP_ADD, 4'd3, 1'b1, 32'd200, 6'd0));
    for (int i = 0; i < 6; i++) send_beat(make_cmd(OP_READ, 4'd0, 1'b0, 32'd0, i[5:0]));
    send_beat(make_cmd(OP_READ, 4'd0, 1'b0, 32'd0, 6'd63));
    send_beat(make_cmd(OP_START, 4'd0, 1'b0, 32'd0, 6'd0));
    send_beat(make_cmd(OP_START, 4'd0, 1'b0, 32'd0, 6'd0));
    send_beat(make_cmd(OP_READ, 4'd0, 1'b0, 32'd0, 6'd0));
    send_beat(make_cmd(OP_STOP, 4'd0, 1'b0, 32'd0, 6'd0));
    send_beat(make_cmd(OP_READ, 4'd0, 1'b0, 32'd0, 6'd4));
    send_beat(make_cmd(OP_ADD, 4'd1, 1'b1, 32'd9, 6'd0));
    send_beat(make_cmd(OP_READ, 4'd0, 1'b0, 32'd0, 6'd1));

    for (int ph = 0; ph < 5; ph++) begin
      write_reversed(cfg_vals[ph]);
      while (n_sent < 22 + (ph + 1) * 220) begin
        // one schedule: arm clear, fill, inspect, usually start, inspect
        send_beat(make_cmd(($urandom_range(0, 1) != 0) ? OP_STOP : OP_START,
                           4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                           $urandom(), 6'($urandom_range(0, 63))));
        n_adds = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 20);
        for (int k = 0; k < n_adds; k++) begin
          if ($urandom_range(0, 9) == 0) it = rand_read();
          else it = rand_add(n_adds > 40);
          send_beat(it);
        end
        repeat ($urandom_range(1, 4)) send_beat(rand_read());
        if ($urandom_range(0, 3) != 0)
          send_beat(make_cmd(OP_START, 4'd0, 1'b0, 32'd0, 6'd0));
        repeat ($urandom_range(1, 4)) send_beat(rand_read());
      end
    end

    settle();
    if (errors == 0)
      $display("** sorted_edge_schedule_builder_core: PASSED **");
    else
      $display("** sorted_edge_schedule_builder_core: FAILED **");
    $finish;
  end

endmodule
